@@ rtl/core/imhq_pkg.sv @@
// Shared codes, widths and capacity for the indexed min-heap queue.
package imhq_pkg;
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_UPDATE = 2'd2;

   localparam logic [2:0] REP_MOVE    = 3'd0;
   localparam logic [2:0] REP_REMOVED = 3'd1;
   localparam logic [2:0] REP_EMPTY   = 3'd2;
   localparam logic [2:0] REP_FULL    = 3'd3;
   localparam logic [2:0] REP_IGNORED = 3'd4;

   localparam int KIND_W   = 2;
   localparam int REP_W    = 3;
   localparam int POS_W    = 10;
   localparam int CAPACITY = 1024;
endpackage

@@ rtl/core/imhq_req_if.sv @@
// Request and response channel interfaces for the heap queue.
interface imhq_req_if #(parameter int ID_BITS = 16, parameter int KEY_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic [imhq_pkg::KIND_W-1:0] kind;
   logic [ID_BITS-1:0]          item_id;
   logic [KEY_BITS-1:0]         item_key;
   logic [imhq_pkg::POS_W-1:0]  position;
   logic                        direction;
   modport source (output valid, kind, item_id, item_key, position, direction, input ready);
   modport sink   (input valid, kind, item_id, item_key, position, direction, output ready);
endinterface

interface imhq_rsp_if #(parameter int ID_BITS = 16, parameter int KEY_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic [imhq_pkg::REP_W-1:0]  report_kind;
   logic [ID_BITS-1:0]          entry_id;
   logic [KEY_BITS-1:0]         entry_key;
   logic [imhq_pkg::POS_W-1:0]  slot;
   logic                        last;
   modport source (output valid, report_kind, entry_id, entry_key, slot, last, input ready);
   modport sink   (input valid, report_kind, entry_id, entry_key, slot, last, output ready);
endinterface

@@ rtl/core/indexed_min_heap_queue.sv @@
// Top level of the indexed min-heap queue: sequencer around one heap memory.
// Flagged cases (full, empty, ignored) are answered from idle without touching the heap;
// the others sift the entry up or down level by level, and output stalls hold them up.
// Throughput: one operation at a time; a new word is taken only when idle with the output
// register free. Each level needs one or two reads, a compare and a write.
// Reset clears the entry count, the sequencer and the output valid; the heap memory is kept.
module indexed_min_heap_queue #(
   parameter int KEY_BITS = 32,
   parameter int ID_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   imhq_req_if.sink   req,
   imhq_rsp_if.source rsp
);
   localparam int CAPACITY = imhq_pkg::CAPACITY;
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = imhq_pkg::POS_W;
   localparam int EW = ID_BITS + KEY_BITS;
   localparam int XW = CW + 1;

   localparam logic [3:0] S_IDLE = 4'd0, S_RDU = 4'd1, S_UPC = 4'd2,
      S_RDL = 4'd3, S_RDR = 4'd4, S_DNC = 4'd5, S_DNR = 4'd6, S_EMIT = 4'd7,
      S_ROOT = 4'd8, S_RDP = 4'd9;

   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_ff;
   logic          we;
   logic [AW-1:0] wa, ra;
   logic [EW-1:0] wd;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   logic [3:0]    st_ff, st_in, ret_ff, ret_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [XW-1:0] pos_ff, pos_in, ch_ff, ch_in;
   logic [EW-1:0] tmp_ff, tmp_in, lft_ff, lft_in;
   logic          fin_ff, fin_in;
   // output register
   logic          ov_ff, ov_in, ol_ff, ol_in;
   logic [2:0]    ok_ff, ok_in;
   logic [EW-1:0] oe_ff, oe_in;
   logic [PW-1:0] os_ff, os_in;

   wire ofree = !ov_ff || rsp.ready;
   wire acc   = req.valid && req.ready;
   assign req.ready = (st_ff == S_IDLE) && ofree;

   wire [KEY_BITS-1:0] tkey = tmp_ff[KEY_BITS-1:0];
   wire [KEY_BITS-1:0] rkey = rd_ff[KEY_BITS-1:0];
   wire [KEY_BITS-1:0] lkey = lft_ff[KEY_BITS-1:0];
   wire [XW-1:0] parent = (pos_ff - XW'(1)) >> 1;
   wire [XW-1:0] lchild = {pos_ff[XW-2:0], 1'b1};

   always_comb begin
      st_in = st_ff; ret_in = ret_ff; cnt_in = cnt_ff; pos_in = pos_ff; ch_in = ch_ff;
      tmp_in = tmp_ff; lft_in = lft_ff; fin_in = fin_ff;
      ov_in = ov_ff && !rsp.ready; ol_in = ol_ff; ok_in = ok_ff; oe_in = oe_ff; os_in = os_ff;
      we = 1'b0; wa = pos_ff[AW-1:0]; wd = tmp_ff; ra = pos_ff[AW-1:0];
      case (st_ff)
         S_IDLE: if (acc) begin
            tmp_in = {req.item_id, req.item_key};
            pos_in = XW'(req.position);
            ok_in = imhq_pkg::REP_IGNORED; oe_in = '0; os_in = '0; ol_in = 1'b1;
            case (req.kind)
               imhq_pkg::KIND_INSERT: begin
                  if (cnt_ff >= CW'(CAPACITY)) begin
                     ok_in = imhq_pkg::REP_FULL; oe_in = tmp_in; ov_in = 1'b1;
                  end else begin
                     pos_in = XW'(cnt_ff); cnt_in = cnt_ff + CW'(1); st_in = S_RDP;
                  end
               end
               imhq_pkg::KIND_REMOVE: begin
                  if (cnt_ff == '0) begin
                     ok_in = imhq_pkg::REP_EMPTY; ov_in = 1'b1;
                  end else begin
                     ra = '0; cnt_in = cnt_ff - CW'(1); st_in = S_ROOT; pos_in = '0;
                  end
               end
               imhq_pkg::KIND_UPDATE: begin
                  if (XW'(req.position) < XW'(cnt_ff)) begin
                     ra = req.position[AW-1:0];
                     st_in = req.direction ? S_RDP : S_RDL;
                     if (!req.direction) st_in = S_RDU;
                     // mark update-up so the sift takes the stored id
                     ret_in = req.direction ? S_UPC : S_IDLE;
                  end else ov_in = 1'b1;
               end
               default: ov_in = 1'b1;
            endcase
         end
         // update-down: read old entry to keep its id
         S_RDU: begin
            tmp_in = {rd_ff[EW-1:KEY_BITS], tkey}; st_in = S_RDL;
         end
         // report removed root, then fetch the last entry if any remain
         S_ROOT: if (ofree) begin
            ok_in = imhq_pkg::REP_REMOVED; oe_in = rd_ff; os_in = '0;
            ol_in = (cnt_ff == '0); ov_in = 1'b1;
            ra = cnt_ff[AW-1:0];
            st_in = (cnt_ff == '0) ? S_IDLE : S_RDR;
         end
         S_RDR: begin
            tmp_in = rd_ff; pos_in = '0; st_in = S_RDL;
         end
         // sift up: fetch parent
         S_RDP: begin
            if (pos_ff == '0) begin fin_in = 1'b1; st_in = S_EMIT; end
            else begin ra = parent[AW-1:0]; st_in = S_UPC; end
            if (ret_ff == S_UPC) tmp_in = {rd_ff[EW-1:KEY_BITS], tkey};
            ret_in = S_IDLE;
         end
         S_UPC: begin
            if (rkey > tkey) begin
               lft_in = rd_ff; fin_in = 1'b0; st_in = S_EMIT; ret_in = S_RDP;
            end else begin
               fin_in = 1'b1; st_in = S_EMIT;
            end
         end
         // sift down: fetch left then right child, if present
         S_RDL: begin
            ret_in = S_IDLE;
            if (lchild >= XW'(cnt_ff)) begin fin_in = 1'b1; st_in = S_EMIT; end
            else begin ra = lchild[AW-1:0]; ch_in = lchild; st_in = S_DNR; end
         end
         S_DNR: begin
            lft_in = rd_ff;
            if (ch_ff + XW'(1) < XW'(cnt_ff)) begin
               ra = AW'(ch_ff + XW'(1)); st_in = S_DNC;
            end else st_in = S_DNC;
            ret_in = (ch_ff + XW'(1) < XW'(cnt_ff)) ? S_RDR : S_IDLE;
         end
         S_DNC: begin
            logic [EW-1:0] c; logic [XW-1:0] ci;
            c = lft_ff; ci = ch_ff;
            if (ret_ff == S_RDR && lkey > rkey) begin c = rd_ff; ci = ch_ff + XW'(1); end
            if (tkey >= c[KEY_BITS-1:0]) begin
               lft_in = c; ch_in = ci; fin_in = 1'b0; st_in = S_EMIT; ret_in = S_RDL;
            end else begin
               fin_in = 1'b1; st_in = S_EMIT; ret_in = S_IDLE;
            end
         end
         // write one entry into its slot and report it
         S_EMIT: if (ofree) begin
            ov_in = 1'b1; ok_in = imhq_pkg::REP_MOVE; os_in = PW'(pos_ff);
            we = 1'b1; wa = pos_ff[AW-1:0];
            if (fin_ff) begin
               wd = tmp_ff; oe_in = tmp_ff; ol_in = 1'b1; st_in = S_IDLE;
            end else begin
               wd = lft_ff; oe_in = lft_ff; ol_in = 1'b0;
               if (ret_ff == S_RDP) begin pos_in = parent; st_in = S_RDP; ret_in = S_RDL; end
               else begin pos_in = ch_ff; st_in = S_RDL; end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ret_ff <= S_IDLE; cnt_ff <= '0; ov_ff <= 1'b0; fin_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ret_ff <= ret_in; cnt_ff <= cnt_in; ov_ff <= ov_in; fin_ff <= fin_in;
      end
      pos_ff <= pos_in; ch_ff <= ch_in; tmp_ff <= tmp_in; lft_ff <= lft_in;
      ol_ff <= ol_in; ok_ff <= ok_in; oe_ff <= oe_in; os_ff <= os_in;
   end

   assign rsp.valid       = ov_ff;
   assign rsp.report_kind = ok_ff;
   assign rsp.entry_id    = oe_ff[EW-1:KEY_BITS];
   assign rsp.entry_key   = oe_ff[KEY_BITS-1:0];
   assign rsp.slot        = os_ff;
   assign rsp.last        = ol_ff;

   // count never exceeds capacity
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(CAPACITY))
      else $error("entry count overflow");
   // a new word is only taken with no result stalled
   a_acc: assert property (@(posedge clock) disable iff (reset) acc |-> ofree)
      else $error("accept while output blocked");
   // the sequencer leaves idle only on an accepted word
   a_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE && !acc) |=> st_ff == S_IDLE)
      else $error("sequencer left idle without a word");
endmodule
